// ===== hdl/pulse_step_resistance_probe_core_macros.svh =====
// Assertion macros shared by the probe core.
// Define ASSERT_OFF to compile every check away.
`ifndef PULSE_STEP_RESISTANCE_PROBE_CORE_MACROS_SVH
`define PULSE_STEP_RESISTANCE_PROBE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define PSRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("probe core check failed");
`define PSRP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("probe core check failed");
`else
`define PSRP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define PSRP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/psrp_pkg.sv =====
`timescale 1ns / 1ps
package psrp_pkg;

  localparam int COUNT_WIDTH    = 16;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int CMD_WIDTH      = 16;
  localparam int DELTA_WIDTH    = 18;
  localparam int SUM_WIDTH      = 32;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 2;

  // Divider sizes: the dividend is the difference of two sums, the divisor
  // is a quarter of the cycle length.
  localparam int DIVIDEND_WIDTH = SUM_WIDTH + 1;
  localparam int DIVISOR_WIDTH  = COUNT_WIDTH - 2;
  localparam int STEP_WIDTH     = $clog2(DIVIDEND_WIDTH + 1);

  localparam logic signed [CMD_WIDTH-1:0] HOLD_RESET = CMD_WIDTH'(-6500);
  localparam logic signed [CMD_WIDTH-1:0] STEP_RESET = CMD_WIDTH'(1000);
  localparam logic [COUNT_WIDTH-1:0]      TICKS_RESET = COUNT_WIDTH'(340);

  localparam logic [DIVIDEND_WIDTH-1:0] DELTA_POS_LIMIT =
    DIVIDEND_WIDTH'(2 ** (DELTA_WIDTH - 1) - 1);
  localparam logic [DIVIDEND_WIDTH-1:0] DELTA_NEG_LIMIT =
    DIVIDEND_WIDTH'(2 ** (DELTA_WIDTH - 1));

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_HOLD_LEVEL,
    REG_STEP_SIZE,
    REG_TICKS_PER_CYCLE,
    REG_RUN_ENABLE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_START,
    ST_DIVIDE,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Phase boundaries of one cycle, derived once at reset and again whenever the length is written.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] last;
    logic [COUNT_WIDTH-1:0] half;
    logic [COUNT_WIDTH-1:0] quarter;
    logic [COUNT_WIDTH-1:0] three_q;
  } limits_t;

  function automatic limits_t cycle_limits(input logic [COUNT_WIDTH-1:0] ticks);
    logic [COUNT_WIDTH-1:0] n;
    logic [COUNT_WIDTH+1:0] triple;
    limits_t lim;
    // A length of zero behaves as a length of one.
    n           = (ticks == '0) ? COUNT_WIDTH'(1) : ticks;
    triple      = {2'b00, n} + {1'b0, n, 1'b0};
    lim.last    = n - COUNT_WIDTH'(1);
    lim.half    = n >> 1;
    lim.quarter = n >> 2;
    lim.three_q = triple[COUNT_WIDTH+1:2];
    return lim;
  endfunction

endpackage

// ===== hdl/psrp_sample_if.sv =====
`timescale 1ns / 1ps
interface psrp_sample_if;
  import psrp_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] current_sample;

  modport source (output valid, output current_sample, input ready);
  modport sink (input valid, input current_sample, output ready);
endinterface

// ===== hdl/psrp_result_if.sv =====
`timescale 1ns / 1ps
interface psrp_result_if;
  import psrp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [CMD_WIDTH-1:0]   voltage_command;
  logic signed [DELTA_WIDTH-1:0] delta_current;
  logic                          delta_updated;
  logic                          divide_fault;

  modport source (
    output valid, output voltage_command, output delta_current,
    output delta_updated, output divide_fault, input ready
  );
  modport sink (
    input valid, input voltage_command, input delta_current,
    input delta_updated, input divide_fault, output ready
  );
endinterface

// ===== hdl/psrp_divider.sv =====
`timescale 1ns / 1ps
module psrp_divider (
  input  logic                                       clk,
  input  logic                                       rst,
  input  psrp_pkg::div_ctrl_t                        ctrl,
  input  logic signed [psrp_pkg::DIVIDEND_WIDTH-1:0] dividend,
  input  logic [psrp_pkg::DIVISOR_WIDTH-1:0]         divisor,
  output psrp_pkg::div_stat_t                        stat,
  output logic [psrp_pkg::DIVIDEND_WIDTH-1:0]        quotient,
  output logic                                       negative
);
  import psrp_pkg::*;

  // Restoring divider on magnitudes, one quotient bit per cycle. The
  // dividend register shifts out at the top and collects quotient bits.
  logic [DIVIDEND_WIDTH-1:0] work;
  logic [DIVISOR_WIDTH-1:0]  rem;
  logic [DIVISOR_WIDTH-1:0]  dvs;
  logic [DIVISOR_WIDTH:0]    trial;
  logic [DIVISOR_WIDTH:0]    trial_sub;
  logic                      fits;
  logic [STEP_WIDTH-1:0]     steps;
  logic                      busy;
  logic                      done;

  assign trial     = {rem, work[DIVIDEND_WIDTH-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        steps <= STEP_WIDTH'(DIVIDEND_WIDTH);
      end else if (busy) begin
        steps <= steps - STEP_WIDTH'(1);
        if (steps == STEP_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      work     <= dividend[DIVIDEND_WIDTH-1] ? DIVIDEND_WIDTH'(-dividend)
                                             : DIVIDEND_WIDTH'(dividend);
      negative <= dividend[DIVIDEND_WIDTH-1];
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      work <= {work[DIVIDEND_WIDTH-2:0], fits};
      rem  <= fits ? trial_sub[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
    end
  end

  assign quotient = work;
  assign stat     = '{busy: busy, done: done};
endmodule

// ===== hdl/pulse_step_resistance_probe_core.sv =====
`timescale 1ns / 1ps
// Square pulse seal test core. Each word on the sample channel is one current
// sample taken at one tick; each word on the result channel is the voltage
// command for that tick, the latest mean current difference between the step
// and hold halves of the cycle, and two flags that mark a cycle end.
// Both channels use valid/ready; a word moves when both are high.
// The cycle length, hold level, step size and run enable are set through the
// plain write port; the user must write them only while the core is idle, as
// the core itself does not enforce this. Writing any of the first three
// restarts the cycle and clears both running sums.
// A sample that does not end a cycle loads its result word into the output
// register at the edge that accepts it. The sample that ends a cycle, when the
// run enable is set and the quarter length is not zero, starts a serial
// divider: the sequencer forms the sum difference, loads the divider, waits
// while it divides one bit per step, sees it finish and hands the word over
// once the output register is free; only then is the next sample taken.
// The core holds one sample at a time. A new sample is taken only when the
// output register is empty or is being read in the same cycle, so a stalled
// receiver stops intake without losing a word.
// Reset loads the default registers, zeroes the phase counter, both sums and
// the stored delta, and leaves the output register empty.
`include "pulse_step_resistance_probe_core_macros.svh"
module pulse_step_resistance_probe_core (
  input  logic                                clk,
  input  logic                                rst,
  psrp_sample_if.sink                         sample,
  psrp_result_if.source                       result,
  input  logic                                cfg_write_en,
  input  logic [psrp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [psrp_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import psrp_pkg::*;

  // Configuration.
  logic signed [CMD_WIDTH-1:0] hold_level;
  logic signed [CMD_WIDTH-1:0] step_size;
  logic                        run_enable;
  limits_t                     limits;

  // Running state.
  seq_state_t                    state;
  seq_state_t                    state_next;
  logic [COUNT_WIDTH-1:0]        phase_count;
  logic [SUM_WIDTH-1:0]          high_sum;
  logic [SUM_WIDTH-1:0]          low_sum;
  logic signed [DELTA_WIDTH-1:0] last_delta;

  // Staging for the cycle end word.
  logic signed [CMD_WIDTH-1:0]      pend_cmd;
  logic signed [DIVIDEND_WIDTH-1:0] diff_reg;

  // Output register.
  logic                          out_valid;
  logic signed [CMD_WIDTH-1:0]   out_cmd;
  logic signed [DELTA_WIDTH-1:0] out_delta;
  logic                          out_upd;
  logic                          out_fault;

  // Divider link.
  div_ctrl_t                 div_ctrl;
  div_stat_t                 div_stat;
  logic [DIVIDEND_WIDTH-1:0] div_quot;
  logic                      div_neg;

  logic                          accept;
  logic                          out_free;
  logic                          in_high_half;
  logic                          cycle_end;
  logic                          quarter_zero;
  logic                          need_div;
  logic                          load_direct;
  logic                          load_done;
  logic                          restart;
  logic [CMD_WIDTH:0]            step_cmd_wide;
  logic signed [CMD_WIDTH-1:0]   step_cmd;
  logic signed [CMD_WIDTH-1:0]   tick_cmd;
  logic [SUM_WIDTH-1:0]          sample_ext;
  logic signed [DELTA_WIDTH-1:0] delta_new;

  psrp_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (diff_reg),
    .divisor  (limits.quarter[DIVISOR_WIDTH-1:0]),
    .stat     (div_stat),
    .quotient (div_quot),
    .negative (div_neg)
  );

  assign out_free     = !out_valid || result.ready;
  assign accept       = sample.valid && sample.ready;
  assign in_high_half = (phase_count < limits.half);
  assign cycle_end    = (phase_count >= limits.last);
  assign quarter_zero = (limits.quarter == '0);
  assign need_div     = run_enable && cycle_end && !quarter_zero;
  assign restart      = cfg_write_en && (cfg_index inside
                        {REG_HOLD_LEVEL, REG_STEP_SIZE, REG_TICKS_PER_CYCLE});
  assign sample_ext   = {{(SUM_WIDTH - SAMPLE_WIDTH){sample.current_sample[SAMPLE_WIDTH-1]}},
                         sample.current_sample};

  // Hold plus step, saturated to the command width.
  assign step_cmd_wide = {hold_level[CMD_WIDTH-1], hold_level}
                       + {step_size[CMD_WIDTH-1], step_size};
  always_comb begin
    if (step_cmd_wide[CMD_WIDTH] != step_cmd_wide[CMD_WIDTH-1]) begin
      step_cmd = step_cmd_wide[CMD_WIDTH] ? {1'b1, {(CMD_WIDTH - 1){1'b0}}}
                                          : {1'b0, {(CMD_WIDTH - 1){1'b1}}};
    end else begin
      step_cmd = step_cmd_wide[CMD_WIDTH-1:0];
    end
  end
  assign tick_cmd = in_high_half ? step_cmd : hold_level;

  // Signed quotient, truncated toward zero and clamped to the delta width.
  always_comb begin
    if (div_neg) begin
      delta_new = (div_quot > DELTA_NEG_LIMIT) ? {1'b1, {(DELTA_WIDTH - 1){1'b0}}}
                                               : -div_quot[DELTA_WIDTH-1:0];
    end else begin
      delta_new = (div_quot > DELTA_POS_LIMIT) ? {1'b0, {(DELTA_WIDTH - 1){1'b1}}}
                                               : div_quot[DELTA_WIDTH-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && need_div) state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_START;
      ST_START:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_stat.done) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sample.ready   = 1'b0;
    div_ctrl.start = 1'b0;
    load_done      = 1'b0;
    case (state)
      ST_IDLE:  sample.ready   = out_free;
      ST_START: div_ctrl.start = 1'b1;
      ST_DONE:  load_done      = out_free;
      default: begin
      end
    endcase
  end
  assign load_direct = accept && !need_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      hold_level  <= HOLD_RESET;
      step_size   <= STEP_RESET;
      run_enable  <= 1'b1;
      limits      <= cycle_limits(TICKS_RESET);
      phase_count <= '0;
      high_sum    <= '0;
      low_sum     <= '0;
      last_delta  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_HOLD_LEVEL:      hold_level <= cfg_data[CMD_WIDTH-1:0];
          REG_STEP_SIZE:       step_size  <= cfg_data[CMD_WIDTH-1:0];
          REG_TICKS_PER_CYCLE: limits     <= cycle_limits(cfg_data[COUNT_WIDTH-1:0]);
          REG_RUN_ENABLE:      run_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (restart) begin
        phase_count <= '0;
        high_sum    <= '0;
        low_sum     <= '0;
      end else if (accept && run_enable) begin
        if (in_high_half) begin
          if (phase_count > limits.quarter) high_sum <= high_sum + sample_ext;
        end else if (phase_count > limits.three_q) begin
          low_sum <= low_sum + sample_ext;
        end
        if (cycle_end) begin
          phase_count <= '0;
          // With a divide pending, the sums stay until the difference is taken.
          if (!need_div) begin
            high_sum <= '0;
            low_sum  <= '0;
          end
        end else begin
          phase_count <= phase_count + COUNT_WIDTH'(1);
        end
      end else if (state == ST_DIFF) begin
        high_sum <= '0;
        low_sum  <= '0;
      end

      if (state == ST_DIVIDE && div_stat.done) last_delta <= delta_new;

      if (load_direct || load_done) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend_cmd <= tick_cmd;
    if (state == ST_DIFF) begin
      diff_reg <= {high_sum[SUM_WIDTH-1], high_sum} - {low_sum[SUM_WIDTH-1], low_sum};
    end
    if (load_direct) begin
      out_cmd   <= run_enable ? tick_cmd : '0;
      out_delta <= last_delta;
      out_upd   <= 1'b0;
      out_fault <= run_enable && cycle_end && quarter_zero;
    end else if (load_done) begin
      out_cmd   <= pend_cmd;
      out_delta <= last_delta;
      out_upd   <= 1'b1;
      out_fault <= 1'b0;
    end
  end

  assign result.valid           = out_valid;
  assign result.voltage_command = out_cmd;
  assign result.delta_current   = out_delta;
  assign result.delta_updated   = out_upd;
  assign result.divide_fault    = out_fault;

  // The divider only runs while the sequencer waits on it.
  `PSRP_ASSERT_IMPLY(a_div_busy_in_divide, clk, rst, div_stat.busy, state == ST_DIVIDE)
  // A cycle end either updates the delta or reports a fault, never both.
  `PSRP_ASSERT_IMPLY(a_flags_exclusive, clk, rst, result.valid,
                     !(result.delta_updated && result.divide_fault))
  // An updated word carries the delta that is stored until it is taken.
  `PSRP_ASSERT_IMPLY(a_update_matches, clk, rst, result.valid && result.delta_updated,
                     result.delta_current == last_delta)
endmodule
